### hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and parameter defaults of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int DEF_WORD_BITS  = 32;

  localparam int ID_W       = 10;  // block_id, granted_block, first_data_block
  localparam int CNT_W      = 11;  // block_count
  localparam int STATUS_W   = 2;
  localparam int BASE_W     = 12;  // block number of a word's bit 0, with headroom
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

### hw/rtl/bba_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bba_bitmap_ram
// One-write, one-read bitmap word store with registered read data.
// ----------------------------------------------------------------------------
module bba_bitmap_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bba_word_scan.sv
// ----------------------------------------------------------------------------
// bba_word_scan
// Finds the lowest clear bit of one bitmap word whose block number lies in
// the window [lo_bound, hi_bound).
// ----------------------------------------------------------------------------
module bba_word_scan #(
  parameter int WORD_BITS = 32,
  parameter int BIT_W     = 5
) (
  input  logic [WORD_BITS-1:0]     word,
  input  logic [bba_pkg::BASE_W-1:0] base,
  input  logic [bba_pkg::BASE_W-1:0] lo_bound,
  input  logic [bba_pkg::BASE_W-1:0] hi_bound,
  output logic                     found,
  output logic [BIT_W-1:0]         offset
);
  import bba_pkg::*;

  logic [WORD_BITS-1:0] cand;

  always_comb begin
    logic [BASE_W-1:0] blk;
    for (int j = 0; j < WORD_BITS; j++) begin
      blk = base + BASE_W'(j);
      cand[j] = !word[j] && (blk >= lo_bound) && (blk < hi_bound);
    end
  end

  // walk down so the lowest candidate wins
  always_comb begin
    found  = 1'b0;
    offset = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found  = 1'b1;
        offset = BIT_W'(j);
      end
    end
  end

endmodule

### hw/rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a bitmap of used blocks.
// ----------------------------------------------------------------------------
// One request is worked at a time. The sequencer reads the bitmap one word
// per cycle through a single scan unit, starting at word 0. A request keeps
// the input side stalled while the words up to its answer's word (the granted
// block's word for an allocate, the block's word for a free) are scanned and
// until its result is taken by the output; an allocate that finds nothing
// scans ceil(limit / WORD_BITS) words, and a free out of range skips the scan.
// After reset the block clears every bitmap word in turn and takes no
// request meanwhile; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
  parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [bba_pkg::ID_W-1:0]        block_id,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bba_pkg::ID_W-1:0]        granted_block,
  output logic [bba_pkg::STATUS_W-1:0]    status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bba_pkg::*;

  localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CAP_INT   = (MAX_BLOCKS < (1 << CNT_W)) ? MAX_BLOCKS : (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0]  LIM_CAP   = CNT_W'(CAP_INT);
  localparam logic [WIDX-1:0]   LAST_WORD = WIDX'(NUM_WORDS - 1);
  localparam logic [BASE_W-1:0] WORD_STEP = BASE_W'(WORD_BITS);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state;
  logic [ID_W-1:0]      first_data_block;
  logic [CNT_W-1:0]     block_count;
  logic [WIDX-1:0]      chk_idx;
  logic [BASE_W-1:0]    chk_base;
  logic                 kind_q;
  logic [ID_W-1:0]      id_q;
  logic [ID_W-1:0]      res_block;
  logic [STATUS_W-1:0]  res_status;

  logic [CNT_W-1:0]     lim;
  logic [BASE_W-1:0]    lim_ext;
  logic [BASE_W-1:0]    fdb_ext;
  logic [BASE_W-1:0]    id_ext;
  logic [BASE_W-1:0]    grant_full;
  logic [BIT_W-1:0]     free_off;
  logic                 in_accept;
  logic                 out_free;
  logic                 past_lim;
  logic                 free_hit;

  logic                 ram_we;
  logic [WIDX-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WIDX-1:0]      ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 scan_found;
  logic [BIT_W-1:0]     scan_off;

  assign lim       = (block_count > LIM_CAP) ? LIM_CAP : block_count;
  assign lim_ext   = {{(BASE_W - CNT_W){1'b0}}, lim};
  assign fdb_ext   = {{(BASE_W - ID_W){1'b0}}, first_data_block};
  assign id_ext    = {{(BASE_W - ID_W){1'b0}}, id_q};
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  assign past_lim   = (chk_base >= lim_ext);
  assign free_hit   = (id_ext < chk_base + WORD_STEP);
  assign grant_full = chk_base + {{(BASE_W - BIT_W){1'b0}}, scan_off};
  assign free_off   = BIT_W'(id_ext - chk_base);

  // read one word ahead while a scan runs; word 0 otherwise
  assign ram_raddr = (state == S_SCAN) ? chk_idx + 1'b1 : '0;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = '0;
    if (state == S_CLR) begin
      ram_we = 1'b1;
    end else if (state == S_SCAN && !past_lim) begin
      if (kind_q == KIND_ALLOC && scan_found) begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << scan_off);
      end else if (kind_q == KIND_FREE && free_hit) begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << free_off);
      end
    end
  end

  bba_bitmap_ram #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (WIDX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bba_word_scan #(
    .WORD_BITS (WORD_BITS),
    .BIT_W     (BIT_W)
  ) u_scan (
    .word     (ram_rdata),
    .base     (chk_base),
    .lo_bound (fdb_ext),
    .hi_bound (lim_ext),
    .found    (scan_found),
    .offset   (scan_off)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_data_block <= '0;
      block_count      <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_DATA:  first_data_block <= cfg_data[ID_W-1:0];
        CFG_BLOCK_COUNT: block_count      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      chk_idx   <= '0;
      chk_base  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          chk_idx <= chk_idx + 1'b1;
          if (chk_idx == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            kind_q   <= kind;
            id_q     <= block_id;
            chk_idx  <= '0;
            chk_base <= '0;
            if (kind == KIND_FREE && {1'b0, block_id} >= lim) begin
              res_block  <= '0;
              res_status <= ST_RANGE;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (past_lim) begin
            res_block  <= '0;
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else if (kind_q == KIND_ALLOC && scan_found) begin
            res_block  <= grant_full[ID_W-1:0];
            res_status <= ST_DONE;
            state      <= S_DONE;
          end else if (kind_q == KIND_FREE && free_hit) begin
            res_block  <= '0;
            res_status <= ST_DONE;
            state      <= S_DONE;
          end else begin
            chk_idx  <= chk_idx + 1'b1;
            chk_base <= chk_base + WORD_STEP;
          end
        end
        S_DONE: begin
          if (out_free) begin
            granted_block <= res_block;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the bitmap is cleared after every reset
  a_clear_after_reset: assert property (@(posedge clk) $fell(rst) |-> state == S_CLR)
    else $error("allocator left reset without clearing the bitmap");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == S_SCAN || state == S_DONE))
    else $error("accepted request did not start a scan or a result");

  a_grant_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !past_lim && kind_q == KIND_ALLOC && scan_found)
      |-> (grant_full >= fdb_ext && grant_full < lim_ext))
    else $error("granted block outside the allocation window");

  a_zero_on_non_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_DONE) |-> granted_block == '0)
    else $error("nonzero block reported with a failing status");

endmodule
